FILE: src/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared sizes, codes and controller/datapath interface types for the
// indexed block search.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_BLOCKS   = 64;
  localparam int VALUE_WIDTH  = 32;

  // Fixed port field widths
  localparam int FIELD_W = 32;
  localparam int POS_W   = 11;
  localparam int IN_W    = 2 * FIELD_W;
  localparam int OUT_W   = ((POS_W + 2 + 7) / 8) * 8;

  localparam int COUNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
  localparam int BIDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_BS_READ,
    S_BS_CMP,
    S_SEL,
    S_START_LO,
    S_START_HI,
    S_SCAN_READ,
    S_SCAN_CMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic key_rd;
    logic bs_cmp;
    logic sel_rd;
    logic start_lo;
    logic start_hi;
    logic scan_rd;
    logic scan_cmp;
    logic resp;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       bs_more;
    logic       sel_valid;
    logic       scan_more;
    logic       match;
    logic       out_free;
  } dp_status_t;

  // Low VALUE_WIDTH bits of the sign-extended field
  function automatic value_t to_value(logic signed [FIELD_W-1:0] x);
    logic signed [63:0] w;
    w = 64'(x);
    return w[VALUE_WIDTH-1:0];
  endfunction

endpackage

FILE: src/block_index_search_top.sv
// ----------------------------------------------------------------------------
// block_index_search_top
// Indexed block search over a table loaded by append transactions.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Clear, append and unused
// codes answer without a search. A search bisects over the keys of the
// closed blocks, fetches the bounds of the selected block and scans it
// until the target is found or the block ends; when no closed block has a
// key at least the target, no block is scanned. The bisection takes at most
// ceil(log2(block_count+1)) steps, and every bisection or scan step costs a
// single-port memory read plus a compare. Items are handled one at a time;
// a new item is taken while the previous result waits in the output
// register, and a result still held there by m_tready stalls the next one
// until it is taken.
// ----------------------------------------------------------------------------
module block_index_search_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [bis_pkg::IN_W-1:0]  s_tdata,  // item_value[31:0], block_key[63:32]
  input  logic [1:0]                s_tuser,  // func
  input  logic                      s_tlast,  // last_in_block
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [bis_pkg::OUT_W-1:0] m_tdata   // found[0], position[11:1], overflow[12]
);
  import bis_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bis_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_func   (s_tuser),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

FILE: src/bis_ctrl.sv
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer for the block search: operation dispatch, bisection over the
// block keys, block bounds fetch, in-block scan and result hand-off.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bis_pkg::dp_status_t status,
  output bis_pkg::dp_cmd_t    cmd
);
  import bis_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = (status.func == FUNC_SEARCH) ? S_BS_READ : S_RESP;
      end
      S_BS_READ: begin
        if (status.bs_more) begin
          cmd.key_rd = 1'b1;
          state_next = S_BS_CMP;
        end else begin
          state_next = S_SEL;
        end
      end
      S_BS_CMP: begin
        cmd.bs_cmp = 1'b1;
        state_next = S_BS_READ;
      end
      S_SEL: begin
        cmd.sel_rd = 1'b1;
        state_next = status.sel_valid ? S_START_LO : S_RESP;
      end
      S_START_LO: begin
        cmd.start_lo = 1'b1;
        state_next   = S_START_HI;
      end
      S_START_HI: begin
        cmd.start_hi = 1'b1;
        state_next   = S_SCAN_READ;
      end
      S_SCAN_READ: begin
        cmd.scan_rd = 1'b1;
        state_next  = status.scan_more ? S_SCAN_CMP : S_RESP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next   = status.match ? S_RESP : S_SCAN_READ;
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.resp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bis_dp.sv
// ----------------------------------------------------------------------------
// bis_dp
// Datapath for the block search: element, key and block start memories,
// table counters, bisection and scan registers, and the output register.
// ----------------------------------------------------------------------------
module bis_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  bis_pkg::dp_cmd_t        cmd,
  output bis_pkg::dp_status_t     status,
  input  logic [bis_pkg::IN_W-1:0] in_data,
  input  logic [1:0]              in_func,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [bis_pkg::OUT_W-1:0] out_data
);
  import bis_pkg::*;

  value_t               element_mem [MAX_ELEMENTS];
  value_t               key_mem     [MAX_BLOCKS];
  logic [COUNT_W-1:0]   start_mem   [MAX_BLOCKS];

  // Table state
  logic [COUNT_W-1:0]   element_count;
  logic [BLK_W-1:0]     block_count;
  logic [COUNT_W-1:0]   open_block_start;

  // Latched operation
  logic [1:0]           op_func;
  value_t               op_value;
  value_t               op_key;
  logic                 op_last;

  // Search registers
  logic [BLK_W-1:0]     lo, hi, sel, mid_q;
  value_t               key_q, elem_q;
  logic [COUNT_W-1:0]   start_q, pos, scan_end;

  // Pending result
  logic                 res_found, res_ovf;
  logic [COUNT_W-1:0]   res_pos;

  logic [BLK_W-1:0]     mid;
  logic [BLK_W:0]       sel_inc;
  logic                 has_next;
  logic                 elem_full, blk_full;
  logic [COUNT_W-1:0]   end_raw;

  assign mid       = lo + ((hi - lo) >> 1);
  assign sel_inc   = {1'b0, sel} + (BLK_W+1)'(1);
  assign has_next  = sel_inc < {1'b0, block_count};
  assign elem_full = element_count >= COUNT_W'(MAX_ELEMENTS);
  assign blk_full  = block_count >= BLK_W'(MAX_BLOCKS);
  assign end_raw   = has_next ? start_q : open_block_start;

  assign status.func      = op_func;
  assign status.bs_more   = lo < hi;
  assign status.sel_valid = sel < block_count;
  assign status.scan_more = pos < scan_end;
  assign status.match     = elem_q == op_value;
  assign status.out_free  = !out_valid || out_ready;

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.exec && op_func == FUNC_APPEND && !elem_full && !(op_last && blk_full)) begin
      element_mem[element_count[ADDR_W-1:0]] <= op_value;
      if (op_last) begin
        key_mem[block_count[BIDX_W-1:0]]   <= op_key;
        start_mem[block_count[BIDX_W-1:0]] <= open_block_start;
      end
    end
    if (cmd.key_rd) begin
      key_q <= key_mem[mid[BIDX_W-1:0]];
    end
    if (cmd.sel_rd) begin
      start_q <= start_mem[sel[BIDX_W-1:0]];
    end else if (cmd.start_lo) begin
      // next block's start; unused when the selected block is the last one
      start_q <= start_mem[sel_inc[BIDX_W-1:0]];
    end
    if (cmd.scan_rd) begin
      elem_q <= element_mem[pos[ADDR_W-1:0]];
    end
  end

  // Table counters
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count    <= '0;
      block_count      <= '0;
      open_block_start <= '0;
    end else if (cmd.exec) begin
      case (op_func)
        FUNC_CLEAR: begin
          element_count    <= '0;
          block_count      <= '0;
          open_block_start <= '0;
        end
        FUNC_APPEND: begin
          if (!elem_full && !(op_last && blk_full)) begin
            element_count <= element_count + COUNT_W'(1);
            if (op_last) begin
              block_count      <= block_count + BLK_W'(1);
              open_block_start <= element_count + COUNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Operation latch, search registers and pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func  <= in_func;
      op_value <= to_value(in_data[FIELD_W-1:0]);
      op_key   <= to_value(in_data[IN_W-1:FIELD_W]);
      op_last  <= in_last;
    end
    if (cmd.exec) begin
      lo        <= '0;
      hi        <= block_count;
      sel       <= block_count;
      res_found <= 1'b0;
      case (op_func)
        FUNC_CLEAR: begin
          res_ovf <= 1'b0;
          res_pos <= '0;
        end
        FUNC_APPEND: begin
          if (elem_full || (op_last && blk_full)) begin
            res_ovf <= 1'b1;
            res_pos <= element_count;
          end else begin
            res_ovf <= 1'b0;
            res_pos <= element_count + COUNT_W'(1);
          end
        end
        default: begin
          res_ovf <= 1'b0;
          res_pos <= element_count;
        end
      endcase
    end
    if (cmd.key_rd) begin
      mid_q <= mid;
    end
    if (cmd.bs_cmp) begin
      if (key_q >= op_value) begin
        sel <= mid_q;
        hi  <= mid_q;
      end else begin
        lo <= mid_q + BLK_W'(1);
      end
    end
    if (cmd.start_lo) begin
      pos <= start_q;
    end
    if (cmd.start_hi) begin
      scan_end <= (end_raw > element_count) ? element_count : end_raw;
    end
    if (cmd.scan_rd && !status.scan_more) begin
      res_pos <= scan_end;
    end
    if (cmd.scan_cmp) begin
      if (status.match) begin
        res_found <= 1'b1;
        res_pos   <= pos;
      end else begin
        pos <= pos + COUNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_data <= OUT_W'({res_ovf, POS_W'(res_pos), res_found});
    end
  end

endmodule
